FILE: hdl/lkvc_pkg.sv
// Package for the LRU key-value cache: operation codes and field widths.
// No dependencies; imported by the interfaces and every module.
package lkvc_pkg;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;
endpackage

FILE: hdl/lkvc_if.sv
// Request and response channel interfaces for the LRU key-value cache.
// Depends on lkvc_pkg for field widths.
interface lkvc_req_if import lkvc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic signed [KEY_W-1:0] key;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, kind, key, value, input ready);
	modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    hit;
	logic signed [VAL_W-1:0] read_value;
	logic                    evicted;
	logic signed [KEY_W-1:0] evicted_key;

	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

FILE: hdl/lkvc_store.sv
// Entry memory of the LRU cache: one write port, one read port, registered read.
// Depends on lkvc_pkg only through the convention of the house import.
module lkvc_store import lkvc_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int DW    = 68,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);
	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

FILE: hdl/lkvc_seq.sv
// Sequencer of the LRU cache: a lookup pass over the entry memory, then a rank update pass.
// Depends on lkvc_pkg and lkvc_if; drives the ports of lkvc_store.
module lkvc_seq import lkvc_pkg::*; #(
	parameter int ENTRIES = 16,
	localparam int IW     = $clog2(ENTRIES),
	localparam int CW     = IW + 1,
	localparam int DW     = KEY_W + VAL_W + IW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CW-1:0] eff_cap,
	lkvc_req_if.sink      req,
	lkvc_rsp_if.source    rsp,
	output logic          rd_en,
	output logic [IW-1:0] rd_addr,
	input  logic [DW-1:0] rd_data,
	output logic          wr_en,
	output logic [IW-1:0] wr_addr,
	output logic [DW-1:0] wr_data
);
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	logic                rd_s1;
	logic [IW-1:0]       idx_s1;
	logic [ENTRIES-1:0]  vld_q;
	logic [CW-1:0]       held_q;

	logic                kind_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	logic                found_q, old_q, free_q;
	logic [IW-1:0]       fidx_q, oidx_q, freeidx_q, tgt_q;
	logic [IW-1:0]       orank_q, frank_q;
	logic [VAL_W-1:0]    fval_q;
	logic [KEY_W-1:0]    okey_q;
	logic [CW-1:0]       limit_q;
	logic                wkey_q, wval_q, hit_q, ev_q;

	logic                rsp_valid_q, rsp_hit_q, rsp_ev_q;
	logic [VAL_W-1:0]    rsp_rd_q;
	logic [KEY_W-1:0]    rsp_evkey_q;

	logic [KEY_W-1:0]    d_key;
	logic [VAL_W-1:0]    d_val;
	logic [IW-1:0]       d_rank;
	logic [IW-1:0]       new_rank;
	logic                pass_end;
	logic                out_free;

	assign d_key  = rd_data[DW-1 -: KEY_W];
	assign d_val  = rd_data[IW +: VAL_W];
	assign d_rank = rd_data[IW-1:0];

	assign req.ready = (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign pass_end  = (cnt_q == CW'(ENTRIES)) && !rd_s1;

	assign rd_en   = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && (cnt_q != CW'(ENTRIES));
	assign rd_addr = cnt_q[IW-1:0];

	// Target goes to rank zero; valid entries younger than the limit age by one.
	always_comb begin
		if (idx_s1 == tgt_q) begin
			new_rank = '0;
		end else if (vld_q[idx_s1] && (CW'(d_rank) < limit_q)) begin
			new_rank = d_rank + IW'(1);
		end else begin
			new_rank = d_rank;
		end
	end

	assign wr_en   = (state_q == ST_UPDATE) && rd_s1;
	assign wr_addr = idx_s1;
	assign wr_data = {(wkey_q && idx_s1 == tgt_q) ? key_q : d_key,
		(wval_q && idx_s1 == tgt_q) ? val_q : d_val, new_rank};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			idx_s1      <= '0;
			vld_q       <= '0;
			held_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			if (rd_en) begin
				cnt_q  <= cnt_q + CW'(1);
				idx_s1 <= rd_addr;
			end
			if (rsp_valid_q && rsp.ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pass_end) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if (found_q || (kind_q == KIND_PUT && held_q >= eff_cap && old_q)) begin
						state_q <= ST_UPDATE;
					end else if (kind_q == KIND_PUT && free_q) begin
						vld_q[freeidx_q] <= 1'b1;
						held_q           <= held_q + CW'(1);
						state_q          <= ST_UPDATE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_UPDATE: begin
					if (pass_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operation registers and scan results.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			kind_q  <= req.kind;
			key_q   <= req.key;
			val_q   <= req.value;
			found_q <= 1'b0;
			old_q   <= 1'b0;
			free_q  <= 1'b0;
		end
		if (state_q == ST_SCAN && rd_s1) begin
			if (vld_q[idx_s1]) begin
				if (!found_q && d_key == key_q) begin
					found_q <= 1'b1;
					fidx_q  <= idx_s1;
					frank_q <= d_rank;
					fval_q  <= d_val;
				end
				if (!old_q || d_rank > orank_q) begin
					old_q   <= 1'b1;
					oidx_q  <= idx_s1;
					orank_q <= d_rank;
					okey_q  <= d_key;
				end
			end else if (!free_q) begin
				free_q    <= 1'b1;
				freeidx_q <= idx_s1;
			end
		end
		if (state_q == ST_DECIDE) begin
			hit_q  <= found_q;
			ev_q   <= 1'b0;
			wkey_q <= 1'b0;
			wval_q <= 1'b0;
			if (found_q) begin
				tgt_q   <= fidx_q;
				limit_q <= CW'(frank_q);
				wval_q  <= (kind_q == KIND_PUT);
			end else if (kind_q == KIND_PUT && held_q >= eff_cap && old_q) begin
				tgt_q   <= oidx_q;
				limit_q <= CW'(orank_q);
				wkey_q  <= 1'b1;
				wval_q  <= 1'b1;
				ev_q    <= 1'b1;
			end else begin
				tgt_q   <= freeidx_q;
				limit_q <= CW'(ENTRIES);
				wkey_q  <= 1'b1;
				wval_q  <= 1'b1;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			rsp_hit_q   <= hit_q;
			rsp_rd_q    <= (hit_q && kind_q == KIND_GET) ? fval_q : '0;
			rsp_ev_q    <= ev_q;
			rsp_evkey_q <= ev_q ? okey_q : '0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.read_value  = rsp_rd_q;
	assign rsp.evicted     = rsp_ev_q;
	assign rsp.evicted_key = rsp_evkey_q;

	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_q) == int'(held_q))
		else $error("entry count disagrees with valid bits");

	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_UPDATE))
		else $error("memory write outside update pass");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write to the same entry in one cycle");

	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");
endmodule

FILE: hdl/lru_key_value_cache_unit.sv
// LRU key-value cache, top level: capacity register, sequencer and entry memory.
// Each request runs a lookup pass and then an update pass over the single read port of
// the entry memory; a get miss skips the update pass. A new request is taken only in
// the idle state, once the result of the last one is in the output register, where a
// finished result waits until it is taken.
// Reset: valid bits, entry count and state clear at once; capacity resets to 16.
module lru_key_value_cache_unit import lkvc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	lkvc_req_if.sink         req,
	lkvc_rsp_if.source       rsp
);
	localparam int IW = $clog2(ENTRIES);
	localparam int CW = IW + 1;
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;
	localparam int DW = KEY_W + VAL_W + IW;

	logic [CAP_W-1:0] cap_q;
	logic [EW-1:0]    cap_ext;
	logic [CW-1:0]    eff_cap;
	logic             rd_en, wr_en;
	logic [IW-1:0]    rd_addr, wr_addr;
	logic [DW-1:0]    rd_data, wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(16);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Zero acts as one; saturate at the entry count.
	assign cap_ext = EW'(cap_q);
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > EW'(ENTRIES)) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = CW'(cap_ext);
		end
	end

	lkvc_seq #(.ENTRIES(ENTRIES)) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.eff_cap (eff_cap),
		.req     (req),
		.rsp     (rsp),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	lkvc_store #(.DEPTH(ENTRIES), .DW(DW)) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);
endmodule
